// File: sv/binary_to_decimal_ascii_defines.svh
// Assertion macros shared by the binary to decimal ASCII converter.
// No dependencies; included by the files that carry assertions.
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define B2DA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define B2DA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/b2da_pkg.sv
// Shared types, constants and functions for the binary to decimal ASCII converter.
// No dependencies.
package b2da_pkg;

   // Default width of the number taken from the request word.
   localparam int DEFAULT_VALUE_BITS = 64;
   // Depth of the queue between converter and character emitter.
   localparam int QUEUE_DEPTH = 2;
   // ASCII code of the character '0', as carried on the 6-bit port.
   localparam logic [5:0] ASCII_ZERO = 6'd48;

   // Decimal digits needed for any value of the given bit width.
   // 1233 / 4096 approximates log10(2) closely enough up to 64 bits.
   function automatic int num_digits(input int bits);
      return ((bits * 1233) >> 12) + 1;
   endfunction

   // Queue status seen by the producer and the consumer.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: sv/binary_to_decimal_ascii.sv
// The bit-serial BCD loop sets the rate of numbers; the converter takes no new number
// until it has pushed the last one, and the emitter walks one digit position per cycle.
// Characters come out at most one per cycle on rsp_valid; the receiver cannot stall.
// Reset (synchronous, active high) empties the queue and idles both halves.
`include "binary_to_decimal_ascii_defines.svh"
module binary_to_decimal_ascii #(
   parameter int VALUE_BITS = b2da_pkg::DEFAULT_VALUE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_value,
   output logic        rsp_valid,
   output logic [5:0]  rsp_digit_char,
   output logic        rsp_last_digit
);
   import b2da_pkg::*;

   localparam int NUM_DIGITS = num_digits(VALUE_BITS);
   localparam int BCD_W      = 4 * NUM_DIGITS;

   queue_status_type  queue_status;
   logic              push;
   logic              pop;
   logic [BCD_W-1:0]  push_data;
   logic [BCD_W-1:0]  head_data;

   // Convert to BCD
   b2da_front #(
      .VALUE_BITS (VALUE_BITS),
      .NUM_DIGITS (NUM_DIGITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .value        (req_value[VALUE_BITS-1:0]),
      .busy         (busy),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   // Decouple converter from emitter
   b2da_fifo #(
      .WIDTH (BCD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .status    (queue_status)
   );

   // Emit characters
   b2da_back #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_status   (queue_status),
      .head_data      (head_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

   `B2DA_ASSERT(a_push_not_full, clock, reset, push |-> !queue_status.full, "push into full queue")
   `B2DA_ASSERT(a_pop_not_empty, clock, reset, pop |-> !queue_status.empty, "pop from empty queue")
   `B2DA_ASSERT(a_start_busy, clock, reset, (start && !busy) |=> busy, "word accepted but converter idle")
   `B2DA_ASSERT(a_char_range, clock, reset, rsp_valid |-> (rsp_digit_char >= ASCII_ZERO && rsp_digit_char <= ASCII_ZERO + 6'd9), "character out of digit range")
   `B2DA_ASSERT_ALWAYS(a_status_excl, clock, reset || !(queue_status.full && queue_status.empty), "queue both full and empty")

endmodule

// File: sv/b2da_fifo.sv
// Small register queue that carries converted BCD words between the two halves.
// Depends on b2da_pkg for the status struct.
module b2da_fifo #(
   parameter int WIDTH = 80,
   parameter int DEPTH = b2da_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [WIDTH-1:0]            push_data,
   input  logic                        pop,
   output logic [WIDTH-1:0]            head_data,
   output b2da_pkg::queue_status_type  status
);
   import b2da_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data    = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// File: sv/b2da_front.sv
// Front half: accepts a request word and converts it to BCD by shift-and-add-3,
// one bit per cycle. Depends on b2da_pkg.
module b2da_front #(
   parameter int VALUE_BITS = b2da_pkg::DEFAULT_VALUE_BITS,
   parameter int NUM_DIGITS = b2da_pkg::num_digits(b2da_pkg::DEFAULT_VALUE_BITS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [VALUE_BITS-1:0]       value,
   output logic                        busy,
   input  b2da_pkg::queue_status_type  queue_status,
   output logic                        push,
   output logic [4*NUM_DIGITS-1:0]     push_data
);
   import b2da_pkg::*;

   localparam int BCD_W = 4 * NUM_DIGITS;
   localparam int CNT_W = $clog2(VALUE_BITS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PUSH
   } state_type;

   state_type        state_ff, state_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [BCD_W-1:0] bcd_adj;

   // Add three to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                        : bcd_ff[4*i +: 4];
      end
   end

   // Sequence load, shift loop and hand-off to the queue
   always_comb begin
      state_in = state_ff;
      value_in = value_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      push     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               value_in = value;
               bcd_in   = '0;
               cnt_in   = CNT_W'(VALUE_BITS);
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            bcd_in   = {bcd_adj[BCD_W-2:0], value_ff[VALUE_BITS-1]};
            value_in = {value_ff[VALUE_BITS-2:0], 1'b0};
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!queue_status.full) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      value_ff <= value_in;
      bcd_ff   <= bcd_in;
      cnt_ff   <= cnt_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign push_data = bcd_ff;

endmodule

// File: sv/b2da_back.sv
// Back half: takes BCD words from the queue and emits one ASCII digit per cycle,
// most significant first, skipping leading zeros. Depends on b2da_pkg.
module b2da_back #(
   parameter int NUM_DIGITS = b2da_pkg::num_digits(b2da_pkg::DEFAULT_VALUE_BITS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  b2da_pkg::queue_status_type  queue_status,
   input  logic [4*NUM_DIGITS-1:0]     head_data,
   output logic                        pop,
   output logic                        rsp_valid,
   output logic [5:0]                  rsp_digit_char,
   output logic                        rsp_last_digit
);
   import b2da_pkg::*;

   localparam int BCD_W = 4 * NUM_DIGITS;
   localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type        state_ff;
   logic [BCD_W-1:0] bcd_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             seen_ff;
   logic             valid_ff;
   logic [5:0]       char_ff;
   logic             last_ff;
   logic [3:0]       top_digit;
   logic             emit;

   assign top_digit = bcd_ff[BCD_W-1 -: 4];
   // Emit once a nonzero digit has shown up, and always on the units digit
   assign emit      = seen_ff || (top_digit != 4'd0) || (idx_ff == '0);
   assign pop       = (state_ff == ST_IDLE) && !queue_status.empty;

   // Walk the digits from the top, one per cycle, with registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (!queue_status.empty) begin
                  bcd_ff   <= head_data;
                  idx_ff   <= IDX_W'(NUM_DIGITS - 1);
                  seen_ff  <= 1'b0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               valid_ff <= emit;
               char_ff  <= ASCII_ZERO + {2'b00, top_digit};
               last_ff  <= (idx_ff == '0);
               seen_ff  <= emit;
               bcd_ff   <= {bcd_ff[BCD_W-5:0], 4'd0};
               idx_ff   <= idx_ff - 1'b1;
               if (idx_ff == '0) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last_digit = last_ff;

endmodule
